### src/sorted_set_merge_stats_macros.svh
// Assertion helpers used by ssms_back.
`ifndef SORTED_SET_MERGE_STATS_MACROS_SVH
`define SORTED_SET_MERGE_STATS_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define SSMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SSMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/ssms_pkg.sv
package ssms_pkg;

  localparam int unsigned HIST_BINS   = 1024;
  localparam int unsigned KMER_LENGTH = 32;
  localparam int unsigned KEY_BITS    = 2 * KMER_LENGTH;
  localparam int unsigned HIST_AW     = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;

  localparam int unsigned ACC_W     = 48;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned BIN_IDX_W = 10;

  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned OPQ_AW    = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CW    = $clog2(OPQ_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_MERGE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_LIMIT_RESET = '1;
  localparam logic [ACC_W-1:0] ACC_MAX           = '1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MISS,
    OP_BOTH,
    OP_READ,
    OP_CLEAR
  } op_kind_e;

  typedef struct packed {
    op_kind_e           kind;
    logic               pop_a;
    logic               pop_b;
    logic               finished;
    logic [CNT_W-1:0]   amount;
    logic [HIST_AW-1:0] addr;
    logic               rd_ok;
  } op_t;

  typedef struct packed {
    logic             pop_a;
    logic             pop_b;
    logic             found_both;
    logic             found_missing;
    logic             finished;
    logic [ACC_W-1:0] common_distinct;
    logic [ACC_W-1:0] common_total;
    logic [ACC_W-1:0] missing_distinct;
    logic [ACC_W-1:0] missing_total;
    logic [ACC_W-1:0] bin_value;
  } res_t;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [CNT_W-1:0] inc);
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + {{(ACC_W + 1 - CNT_W){1'b0}}, inc};
    return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
  endfunction

endpackage

### src/ssms_front.sv
module ssms_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssms_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [ssms_pkg::MODE_W-1:0]   mode_i,
  input  logic [ssms_pkg::KEY_W-1:0]    key_a_i,
  input  logic [ssms_pkg::CNT_W-1:0]    count_a_i,
  input  logic                          a_valid_i,
  input  logic [ssms_pkg::KEY_W-1:0]    key_b_i,
  input  logic [ssms_pkg::CNT_W-1:0]    count_b_i,
  input  logic                          b_valid_i,
  input  logic [ssms_pkg::BIN_IDX_W-1:0] bin_index_i,
  input  logic                          q_full_i,
  input  logic                          init_busy_i,
  output logic                          op_valid_o,
  output ssms_pkg::op_t                 op_o
);
  import ssms_pkg::*;

  logic [CNT_W-1:0]    count_limit_q;
  logic [KEY_BITS-1:0] ka;
  logic [KEY_BITS-1:0] kb;
  logic [HIST_AW-1:0]  miss_bin;
  op_t                 op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q <= COUNT_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_limit_q <= cfg_data_i;
    end
  end

  assign ka = key_a_i[KEY_BITS-1:0];
  assign kb = key_b_i[KEY_BITS-1:0];

  // Counts at or above the last bin land in the last bin.
  assign miss_bin = (32'(count_a_i) >= HIST_BINS - 1) ? HIST_AW'(HIST_BINS - 1)
                                                       : HIST_AW'(count_a_i);

  always_comb begin
    op          = '0;
    op.kind     = OP_NONE;
    unique case (mode_i)
      MODE_MERGE: begin
        priority if (!a_valid_i) begin
          op.finished = 1'b1;
        end else if (count_a_i > count_limit_q) begin
          op.pop_a = 1'b1;
        end else if (!b_valid_i || ka < kb) begin
          op.pop_a  = 1'b1;
          op.kind   = OP_MISS;
          op.amount = count_a_i;
          op.addr   = miss_bin;
        end else if (ka == kb) begin
          op.pop_a  = 1'b1;
          op.pop_b  = 1'b1;
          op.kind   = OP_BOTH;
          op.amount = (count_a_i < count_b_i) ? count_a_i : count_b_i;
        end else begin
          op.pop_b = 1'b1;
        end
      end
      MODE_READ: begin
        op.kind  = OP_READ;
        op.addr  = HIST_AW'(bin_index_i);
        op.rd_ok = 32'(bin_index_i) < HIST_BINS;
      end
      MODE_CLEAR: begin
        op.kind = OP_CLEAR;
      end
      default: begin
        op.kind = OP_NONE;
      end
    endcase
  end

  assign full_o     = q_full_i || init_busy_i;
  assign op_valid_o = push_i && !full_o;
  assign op_o       = op;

endmodule

### src/ssms_op_queue.sv
module ssms_op_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssms_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ssms_pkg::op_t op_o
);
  import ssms_pkg::*;

  op_t               slot_q [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OPQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OPQ_CW-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == OPQ_CW'(OPQ_DEPTH);
  assign valid_o = cnt_q != '0;
  assign op_o    = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

### src/ssms_back.sv
`include "sorted_set_merge_stats_macros.svh"

module ssms_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  ssms_pkg::op_t op_i,
  output logic          op_pop_o,
  output logic          init_busy_o,
  output logic          empty_o,
  input  logic          pop_i,
  output ssms_pkg::res_t res_o
);
  import ssms_pkg::*;

  logic [ACC_W-1:0]   hist_mem [HIST_BINS];
  logic [ACC_W-1:0]   mem_rd_q;
  logic               mem_we;
  logic [HIST_AW-1:0] mem_waddr;
  logic [ACC_W-1:0]   mem_wdata;

  logic               s2_valid_q, s2_valid_d;
  op_t                s2_op_q;
  logic               fwd_hit_q, fwd_hit_d;
  logic [ACC_W-1:0]   fwd_data_q;
  logic               sweep_q, sweep_d;
  logic               init_q, init_d;
  logic [HIST_AW-1:0] clr_addr_q, clr_addr_d;

  logic [ACC_W-1:0]   cd_q, cd_d;
  logic [ACC_W-1:0]   ct_q, ct_d;
  logic [ACC_W-1:0]   md_q, md_d;
  logic [ACC_W-1:0]   mt_q, mt_d;

  res_t               out_q [2];
  logic               out_wr_q;
  logic               out_rd_q;
  logic [1:0]         out_cnt_q, out_cnt_d;
  logic               out_full;
  logic               out_pop;

  logic               issue;
  logic               s2_fire;
  logic [ACC_W-1:0]   bin_old;
  logic [ACC_W-1:0]   bin_new;
  res_t               res;

  assign out_full = out_cnt_q == 2'd2;
  assign out_pop  = pop_i && !empty_o;
  assign s2_fire  = s2_valid_q && !out_full && !sweep_q;
  assign issue    = op_valid_i && !sweep_q && (!s2_valid_q || s2_fire);
  assign op_pop_o = issue;
  assign init_busy_o = init_q;

  // The read issued in the same cycle as a write to the same bin sees the old
  // content, so the written value is carried along with the item.
  assign bin_old = fwd_hit_q ? fwd_data_q : mem_rd_q;
  assign bin_new = sat_add(bin_old, CNT_W'(1));

  assign mem_we    = sweep_q || (s2_fire && s2_op_q.kind == OP_MISS);
  assign mem_waddr = sweep_q ? clr_addr_q : s2_op_q.addr;
  assign mem_wdata = sweep_q ? '0 : bin_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      mem_rd_q   <= hist_mem[op_i.addr];
      fwd_data_q <= bin_new;
      s2_op_q    <= op_i;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    fwd_hit_d  = fwd_hit_q;
    if (issue) begin
      s2_valid_d = 1'b1;
      fwd_hit_d  = s2_fire && s2_op_q.kind == OP_MISS && s2_op_q.addr == op_i.addr;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
      fwd_hit_d  = 1'b0;
    end
  end

  always_comb begin
    sweep_d    = sweep_q;
    init_d     = init_q;
    clr_addr_d = clr_addr_q;
    if (sweep_q) begin
      if (clr_addr_q == HIST_AW'(HIST_BINS - 1)) begin
        sweep_d = 1'b0;
        init_d  = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end else if (issue && op_i.kind == OP_CLEAR) begin
      sweep_d    = 1'b1;
      clr_addr_d = '0;
    end
  end

  always_comb begin
    cd_d = cd_q;
    ct_d = ct_q;
    md_d = md_q;
    mt_d = mt_q;
    unique case (s2_op_q.kind)
      OP_MISS: begin
        md_d = sat_add(md_q, CNT_W'(1));
        mt_d = sat_add(mt_q, s2_op_q.amount);
      end
      OP_BOTH: begin
        cd_d = sat_add(cd_q, CNT_W'(1));
        ct_d = sat_add(ct_q, s2_op_q.amount);
      end
      OP_CLEAR: begin
        cd_d = '0;
        ct_d = '0;
        md_d = '0;
        mt_d = '0;
      end
      default: begin
        cd_d = cd_q;
      end
    endcase
  end

  always_comb begin
    res                  = '0;
    res.pop_a            = s2_op_q.pop_a;
    res.pop_b            = s2_op_q.pop_b;
    res.found_both       = s2_op_q.kind == OP_BOTH;
    res.found_missing    = s2_op_q.kind == OP_MISS;
    res.finished         = s2_op_q.finished;
    res.common_distinct  = cd_d;
    res.common_total     = ct_d;
    res.missing_distinct = md_d;
    res.missing_total    = mt_d;
    res.bin_value        = (s2_op_q.kind == OP_READ && s2_op_q.rd_ok) ? bin_old : '0;
  end

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (s2_fire && !out_pop) begin
      out_cnt_d = out_cnt_q + 1'b1;
    end else if (!s2_fire && out_pop) begin
      out_cnt_d = out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      sweep_q    <= 1'b1;
      init_q     <= 1'b1;
      clr_addr_q <= '0;
      cd_q       <= '0;
      ct_q       <= '0;
      md_q       <= '0;
      mt_q       <= '0;
      out_wr_q   <= 1'b0;
      out_rd_q   <= 1'b0;
      out_cnt_q  <= '0;
    end else begin
      s2_valid_q <= s2_valid_d;
      fwd_hit_q  <= fwd_hit_d;
      sweep_q    <= sweep_d;
      init_q     <= init_d;
      clr_addr_q <= clr_addr_d;
      if (s2_fire) begin
        cd_q     <= cd_d;
        ct_q     <= ct_d;
        md_q     <= md_d;
        mt_q     <= mt_d;
        out_wr_q <= ~out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= ~out_rd_q;
      end
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_q[out_wr_q] <= res;
    end
  end

  assign empty_o = out_cnt_q == 2'd0;
  assign res_o   = out_q[out_rd_q];

  `SSMS_ASSERT(a_init_no_issue, init_q |-> !issue, "item issued during the reset sweep")
  `SSMS_ASSERT(a_out_cnt_bound, out_cnt_q <= 2'd2, "result queue count out of range")
  `SSMS_ASSERT(a_fwd_needs_item, fwd_hit_q |-> s2_valid_q, "forward flag without an item")
  `SSMS_ASSERT(a_clear_zeroes, (s2_fire && s2_op_q.kind == OP_CLEAR) |=> (cd_q == '0 && ct_q == '0 && md_q == '0 && mt_q == '0), "tallies not cleared")

endmodule

### src/sorted_set_merge_stats.sv
// Channel  Direction  Handshake                 Payload
// input    in         push / full               mode_i .. bin_index_i
// result   out        empty / pop               pop_a_o .. bin_value_o
// config   in         cfg_valid_i / cfg_ready_o cfg_data_i (count limit)
//
// One item per cycle sustained unless a queue is full or a sweep runs; a result
// passes op queue, histogram read, update, limited by the histogram read-modify-write.
// After reset the histogram is swept to zero bin by bin while full is high.
// A clear item sweeps the histogram again, holding later items until the sweep ends.
// A four-entry op queue and a two-entry result queue absorb stalls on either side.
module sorted_set_merge_stats (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssms_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [ssms_pkg::MODE_W-1:0]    mode_i,
  input  logic [ssms_pkg::KEY_W-1:0]     key_a_i,
  input  logic [ssms_pkg::CNT_W-1:0]     count_a_i,
  input  logic                           a_valid_i,
  input  logic [ssms_pkg::KEY_W-1:0]     key_b_i,
  input  logic [ssms_pkg::CNT_W-1:0]     count_b_i,
  input  logic                           b_valid_i,
  input  logic [ssms_pkg::BIN_IDX_W-1:0] bin_index_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           pop_a_o,
  output logic                           pop_b_o,
  output logic                           found_both_o,
  output logic                           found_missing_o,
  output logic                           finished_o,
  output logic [ssms_pkg::ACC_W-1:0]     common_distinct_o,
  output logic [ssms_pkg::ACC_W-1:0]     common_total_o,
  output logic [ssms_pkg::ACC_W-1:0]     missing_distinct_o,
  output logic [ssms_pkg::ACC_W-1:0]     missing_total_o,
  output logic [ssms_pkg::ACC_W-1:0]     bin_value_o
);
  import ssms_pkg::*;

  logic q_full;
  logic init_busy;
  logic fe_valid;
  op_t  fe_op;
  logic q_valid;
  op_t  q_op;
  logic q_pop;
  res_t res;

  ssms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .key_a_i     (key_a_i),
    .count_a_i   (count_a_i),
    .a_valid_i   (a_valid_i),
    .key_b_i     (key_b_i),
    .count_b_i   (count_b_i),
    .b_valid_i   (b_valid_i),
    .bin_index_i (bin_index_i),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .op_valid_o  (fe_valid),
    .op_o        (fe_op)
  );

  ssms_op_queue u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .op_i    (fe_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  ssms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_op),
    .op_pop_o    (q_pop),
    .init_busy_o (init_busy),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign pop_a_o            = res.pop_a;
  assign pop_b_o            = res.pop_b;
  assign found_both_o       = res.found_both;
  assign found_missing_o    = res.found_missing;
  assign finished_o         = res.finished;
  assign common_distinct_o  = res.common_distinct;
  assign common_total_o     = res.common_total;
  assign missing_distinct_o = res.missing_distinct;
  assign missing_total_o    = res.missing_total;
  assign bin_value_o        = res.bin_value;

endmodule
